/* hw/rtl/sstf_pkg.sv */
package sstf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int REQUESTERS  = 64;
  localparam int MAX_RESULTS = 16;
  localparam int FAR_LIMIT   = 1000;
  localparam int CAP_RESET   = 16;

  localparam int ID_W   = 6;
  localparam int TRK_W  = 10;
  localparam int CAP_W  = 5;
  localparam int LIVE_W = 7;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    STATUS_SERVED   = 3'd0,
    STATUS_QUEUED   = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_BUSY     = 3'd3,
    STATUS_FINISHED = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_QUEUE_CAPACITY    = 1'b0,
    CFG_ACTIVE_REQUESTERS = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_CHECK,
    ENG_SCAN,
    ENG_REMOVE
  } engine_state_e;

  typedef struct packed {
    logic [ID_W-1:0]  requester_id;
    logic [TRK_W-1:0] track;
    logic             final_request;
  } request_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  served_requester;
    logic [TRK_W-1:0] served_track;
    logic             last;
  } result_t;

endpackage

/* hw/rtl/sstf_front.sv */
module sstf_front import sstf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // requester_id [5:0], track [15:6]
  input  logic        s_axis_tlast,  // final_request
  output logic        req_valid_o,
  output request_t    req_o,
  input  logic        req_pop_i
);

  request_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  request_t   incoming;

  always_comb begin
    incoming.requester_id  = s_axis_tdata[ID_W-1:0];
    incoming.track         = s_axis_tdata[ID_W+TRK_W-1:ID_W];
    incoming.final_request = s_axis_tlast;
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (cnt_q != 2'd0);
  assign pop           = req_pop_i && req_valid_o;
  assign req_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= incoming;
  end

endmodule

/* hw/rtl/sstf_engine.sv */
module sstf_engine import sstf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  request_t    req_i,
  output logic        req_pop_o,
  input  logic        cfg_valid_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        res_ready_i
);

  engine_state_e state_q, state_d;

  logic [CAP_W-1:0]      cap_q;
  logic [LIVE_W-1:0]     live_q;
  logic [CNT_W-1:0]      count_q;
  logic [TRK_W-1:0]      head_q;
  logic [REQUESTERS-1:0] pend_q;
  logic                  hold_valid_q;
  logic                  done_q;
  logic [RES_W-1:0]      n_q;

  logic [TRK_W-1:0] qtrk_q [QUEUE_DEPTH];
  logic [ID_W-1:0]  qreq_q [QUEUE_DEPTH];
  logic             qfin_q [QUEUE_DEPTH];

  logic [IDX_W-1:0] idx_q, pick_q;
  logic [TRK_W-1:0] best_q;
  logic [TRK_W-1:0] cand_trk_q;
  logic [ID_W-1:0]  cand_req_q;
  logic             cand_fin_q;
  status_e          hold_status_q;
  logic [ID_W-1:0]  hold_req_q;
  logic [TRK_W-1:0] hold_trk_q;

  logic [CNT_W-1:0] eff_cap, target;
  logic             finished, serve_cond, id_busy, full;
  logic             do_accept, do_enq, do_remove, emit, last_idx;
  logic [TRK_W-1:0] scan_trk, seek_dist;

  always_comb begin
    eff_cap  = (int'(cap_q) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_q);
    target   = (int'(live_q) >= int'(eff_cap)) ? eff_cap : CNT_W'(live_q);
    finished = (live_q == '0) || (eff_cap == '0);
    full     = (count_q >= eff_cap);
    id_busy  = (int'(req_i.requester_id) >= REQUESTERS) || pend_q[req_i.requester_id];
    // serving continues while the queue is exactly as full as it may get
    serve_cond = !done_q && (int'(n_q) < MAX_RESULTS) && !finished &&
                 (count_q != '0) && (count_q == target);
    scan_trk  = qtrk_q[idx_q];
    seek_dist = (head_q >= scan_trk) ? (head_q - scan_trk) : (scan_trk - head_q);
    last_idx  = (CNT_W'(idx_q) == count_q - 1'b1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: begin
        if (req_valid_i) state_d = ENG_CHECK;
      end
      ENG_CHECK: begin
        if (hold_valid_q) begin
          if (res_ready_i) state_d = serve_cond ? ENG_SCAN : ENG_IDLE;
        end else if (serve_cond) begin
          state_d = ENG_SCAN;
        end else if (res_ready_i) begin
          state_d = ENG_IDLE;
        end
      end
      ENG_SCAN: begin
        if (last_idx) state_d = ENG_REMOVE;
      end
      ENG_REMOVE: state_d = ENG_CHECK;
      default:    state_d = ENG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_pop_o   = (state_q == ENG_IDLE) && req_valid_i;
    res_valid_o = (state_q == ENG_CHECK) && (hold_valid_q || !serve_cond);
    res_o.status           = hold_valid_q ? hold_status_q : STATUS_QUEUED;
    res_o.served_requester = hold_valid_q ? hold_req_q : '0;
    res_o.served_track     = hold_valid_q ? hold_trk_q : '0;
    res_o.last             = !serve_cond;
  end

  assign do_accept = req_pop_o;
  assign do_enq    = do_accept && !finished && !full && !id_busy;
  assign do_remove = (state_q == ENG_REMOVE);
  assign emit      = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ENG_IDLE;
      cap_q        <= CAP_W'(CAP_RESET);
      live_q       <= '0;
      count_q      <= '0;
      head_q       <= '0;
      pend_q       <= '0;
      hold_valid_q <= 1'b0;
      done_q       <= 1'b0;
      n_q          <= '0;
    end else begin
      state_q <= state_d;
      if (do_accept) begin
        done_q       <= finished;
        hold_valid_q <= !do_enq;
        n_q          <= (do_enq || finished) ? RES_W'(0) : RES_W'(1);
      end
      if (do_enq) begin
        count_q                     <= count_q + 1'b1;
        pend_q[req_i.requester_id]  <= 1'b1;
      end
      if (emit && hold_valid_q) hold_valid_q <= 1'b0;
      if (do_remove) begin
        count_q            <= count_q - 1'b1;
        head_q             <= cand_trk_q;
        pend_q[cand_req_q] <= 1'b0;
        if (cand_fin_q && (live_q != '0)) live_q <= live_q - 1'b1;
        hold_valid_q       <= 1'b1;
        n_q                <= n_q + 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_QUEUE_CAPACITY:    cap_q  <= cfg_data_i[CAP_W-1:0];
          CFG_ACTIVE_REQUESTERS: live_q <= cfg_data_i[LIVE_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_accept) begin
      hold_status_q <= finished ? STATUS_FINISHED : (full ? STATUS_FULL : STATUS_BUSY);
      hold_req_q    <= '0;
      hold_trk_q    <= '0;
    end
    if (do_enq) begin
      qtrk_q[count_q[IDX_W-1:0]] <= req_i.track;
      qreq_q[count_q[IDX_W-1:0]] <= req_i.requester_id;
      qfin_q[count_q[IDX_W-1:0]] <= req_i.final_request;
    end
    if (state_q == ENG_CHECK) idx_q <= '0;
    if (state_q == ENG_SCAN) begin
      idx_q <= idx_q + 1'b1;
      // entry zero is the default pick; later entries win only when strictly nearer
      if (idx_q == '0) begin
        pick_q     <= '0;
        best_q     <= (seek_dist < TRK_W'(FAR_LIMIT)) ? seek_dist : TRK_W'(FAR_LIMIT);
        cand_trk_q <= scan_trk;
        cand_req_q <= qreq_q[idx_q];
        cand_fin_q <= qfin_q[idx_q];
      end else if (seek_dist < best_q) begin
        pick_q     <= idx_q;
        best_q     <= seek_dist;
        cand_trk_q <= scan_trk;
        cand_req_q <= qreq_q[idx_q];
        cand_fin_q <= qfin_q[idx_q];
      end
    end
    if (do_remove) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (IDX_W'(j) >= pick_q) begin
          qtrk_q[j] <= qtrk_q[j+1];
          qreq_q[j] <= qreq_q[j+1];
          qfin_q[j] <= qfin_q[j+1];
        end
      end
      hold_status_q <= STATUS_SERVED;
      hold_req_q    <= cand_req_q;
      hold_trk_q    <= cand_trk_q;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= QUEUE_DEPTH)
    else $error("queue count above depth");

  a_pending_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == int'(count_q))
    else $error("pending flags disagree with queue count");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ENG_SCAN) |-> (count_q != '0))
    else $error("scan started on an empty queue");

  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ENG_REMOVE) |=> (count_q + 1'b1 == $past(count_q)))
    else $error("removal did not drop exactly one entry");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_q) <= MAX_RESULTS)
    else $error("too many results for one request");
`endif

endmodule

/* hw/rtl/sstf_disk_request_scheduler_unit.sv */
// an accepted request passes from the idle state to the check state, where a rejected or
// queued-only request gives its word to the output register; each serve adds a nearest-track
// scan of one queued entry per cycle, a removal state and a return to the check state to decide
// on more serves; a new request is taken only once the engine is back in idle after its last word
// reset: asynchronous active low; clears control, head, counts and pending flags,
// capacity back to 16, live requesters to 0; queue entries stay undefined, no clearing pass
module sstf_disk_request_scheduler_unit import sstf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // requester_id [5:0], track [15:6]
  input  logic        s_axis_tlast,   // final_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // served_requester [5:0], served_track [15:6]
  output logic [2:0]  m_axis_tuser,   // status [2:0]
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  logic     req_valid, req_pop;
  request_t req;
  logic     res_valid, res_ready;
  result_t  res;
  logic     out_valid_q;
  result_t  out_q;

  sstf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_pop_i     (req_pop)
  );

  sstf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign cfg_ready_o = 1'b1;

  // output register, refilled in the cycle the held word leaves
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.served_track, out_q.served_requester};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule
